// File: hdl/sld_pkg.sv
// Shared types and constants of the serial load/dump command engine.
package sld_pkg;

  // Command and reply characters on the serial link.
  localparam logic [7:0] CharLoad  = 8'h4C;  // 'L'
  localparam logic [7:0] CharDump  = 8'h44;  // 'D'
  localparam logic [7:0] CharGo    = 8'h47;  // 'G'
  localparam logic [7:0] CharPing  = 8'h50;  // 'P'
  localparam logic [7:0] CharOk    = 8'h4B;  // 'K'
  localparam logic [7:0] CharError = 8'h45;  // 'E'
  localparam logic [7:0] CharPong  = 8'h4F;  // 'O'

  // Default number of entries in the queue between the parser and the result port.
  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic {
    ITEM_LINK = 1'b0,
    ITEM_READ = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    RK_TX    = 2'd0,
    RK_WRITE = 2'd1,
    RK_READ  = 2'd2,
    RK_JUMP  = 2'd3
  } result_kind_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_LOAD = 2'd1,
    OP_DUMP = 2'd2,
    OP_GO   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ADDR = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CSUM = 3'd4,
    PH_DUMP = 3'd5
  } phase_e;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   tx_byte;
    logic [31:0]  mem_address;
    logic [7:0]   write_data;
  } res_t;

  // All results caused by one input item; res_b is used only when two is set.
  typedef struct packed {
    logic two;
    res_t res_a;
    res_t res_b;
  } entry_t;

  // Push request from the parser into the queue.
  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

// File: hdl/sld_if.sv
// Handshake interfaces of the input item channel and the result channel.
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic [7:0] read_data;

  modport source (output valid, command, rx_byte, read_data, input ready);
  modport sink   (input valid, command, rx_byte, read_data, output ready);
endinterface

interface sld_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  tx_byte;
  logic [31:0] mem_address;
  logic [7:0]  write_data;
  logic        last_in_run;

  modport source (output valid, result_kind, tx_byte, mem_address, write_data, last_in_run,
                  input ready);
  modport sink   (input valid, result_kind, tx_byte, mem_address, write_data, last_in_run,
                  output ready);
endinterface

// File: hdl/sld_front.sv
// Command parser: accepts input items, tracks the command phase and builds result entries.
module sld_front import sld_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  sld_in_if.sink in_i,
  input  logic  space_i,
  output push_t push_o
);

  phase_e      phase_q, phase_d;
  op_e         op_q, op_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] base_q, base_d;
  logic [31:0] len_q, len_d;
  logic [31:0] addr_q, addr_d;   // base address plus byte index
  logic [31:0] rem_q, rem_d;     // byte length minus byte index
  logic [7:0]  xor_q, xor_d;

  logic        accept;
  logic [31:0] rem_dec, addr_inc, base_sh, len_sh;
  logic [1:0]  cnt_inc;

  assign in_i.ready = space_i;
  assign accept     = in_i.valid & space_i;
  assign rem_dec    = rem_q - 32'd1;
  assign addr_inc   = addr_q + 32'd1;
  assign base_sh    = {base_q[23:0], in_i.rx_byte};
  assign len_sh     = {len_q[23:0], in_i.rx_byte};
  assign cnt_inc    = cnt_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= OP_NONE;
      cnt_q   <= '0;
      base_q  <= '0;
      len_q   <= '0;
      addr_q  <= '0;
      rem_q   <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
      len_q   <= len_d;
      addr_q  <= addr_d;
      rem_q   <= rem_d;
      xor_q   <= xor_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    base_d  = base_q;
    len_d   = len_q;
    addr_d  = addr_q;
    rem_d   = rem_q;
    xor_d   = xor_q;
    push_o  = '0;

    if (accept) begin
      if (in_i.command == ITEM_READ) begin
        if (phase_q == PH_DUMP) begin
          push_o.push              = 1'b1;
          push_o.entry.res_a.kind  = RK_TX;
          push_o.entry.res_a.tx_byte = in_i.read_data;
          rem_d                    = rem_dec;
          if (rem_dec != 32'd0) begin
            push_o.entry.two                 = 1'b1;
            push_o.entry.res_b.kind          = RK_READ;
            push_o.entry.res_b.mem_address   = addr_inc;
            addr_d                           = addr_inc;
          end else begin
            phase_d = PH_IDLE;
            op_d    = OP_NONE;
            cnt_d   = '0;
          end
        end
      end else begin
        case (phase_q)
          PH_ADDR: begin
            base_d = base_sh;
            cnt_d  = cnt_inc;
            if (cnt_inc == 2'd0) begin
              if (op_q == OP_GO) begin
                push_o.push                    = 1'b1;
                push_o.entry.res_a.kind        = RK_JUMP;
                push_o.entry.res_a.mem_address = base_sh;
                phase_d                        = PH_IDLE;
                op_d                           = OP_NONE;
              end else begin
                phase_d = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            len_d = len_sh;
            cnt_d = cnt_inc;
            if (cnt_inc == 2'd0) begin
              xor_d  = '0;
              addr_d = base_q;
              rem_d  = len_sh;
              if (op_q == OP_LOAD) begin
                phase_d = (len_sh == 32'd0) ? PH_CSUM : PH_DATA;
              end else if (len_sh == 32'd0) begin
                phase_d = PH_IDLE;
                op_d    = OP_NONE;
              end else begin
                phase_d                        = PH_DUMP;
                push_o.push                    = 1'b1;
                push_o.entry.res_a.kind        = RK_READ;
                push_o.entry.res_a.mem_address = base_q;
              end
            end
          end
          PH_DATA: begin
            push_o.push                    = 1'b1;
            push_o.entry.res_a.kind        = RK_WRITE;
            push_o.entry.res_a.mem_address = addr_q;
            push_o.entry.res_a.write_data  = in_i.rx_byte;
            xor_d  = xor_q ^ in_i.rx_byte;
            addr_d = addr_inc;
            rem_d  = rem_dec;
            if (rem_dec == 32'd0) begin
              phase_d = PH_CSUM;
            end
          end
          PH_CSUM: begin
            push_o.push                = 1'b1;
            push_o.entry.res_a.kind    = RK_TX;
            push_o.entry.res_a.tx_byte = (xor_q == in_i.rx_byte) ? CharOk : CharError;
            phase_d                    = PH_IDLE;
            op_d                       = OP_NONE;
            cnt_d                      = '0;
          end
          PH_DUMP: begin
            // Link bytes are dropped while a dump read is outstanding.
          end
          default: begin
            phase_d = PH_IDLE;
            op_d    = OP_NONE;
            cnt_d   = '0;
            if (in_i.rx_byte == CharLoad || in_i.rx_byte == CharDump ||
                in_i.rx_byte == CharGo) begin
              op_d    = (in_i.rx_byte == CharLoad) ? OP_LOAD :
                        (in_i.rx_byte == CharDump) ? OP_DUMP : OP_GO;
              phase_d = PH_ADDR;
              base_d  = '0;
              len_d   = '0;
            end else if (in_i.rx_byte == CharPing) begin
              push_o.push                = 1'b1;
              push_o.entry.res_a.kind    = RK_TX;
              push_o.entry.res_a.tx_byte = CharPong;
            end
          end
        endcase
      end
    end
  end

endmodule

// File: hdl/sld_fifo.sv
// Small register queue of result entries between the parser and the result port.
module sld_fifo import sld_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.push & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: hdl/sld_back.sv
// Result sequencer: sends the one or two results of the head queue entry in order.
module sld_back import sld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  entry_t     head_i,
  input  logic       empty_i,
  output logic       pop_o,
  sld_out_if.source  out_o
);

  logic sel_q, sel_d;
  logic last, xfer;
  res_t cur;

  assign cur  = sel_q ? head_i.res_b : head_i.res_a;
  assign last = ~head_i.two | sel_q;
  assign xfer = out_o.valid & out_o.ready;

  assign out_o.valid       = ~empty_i;
  assign out_o.result_kind = cur.kind;
  assign out_o.tx_byte     = cur.tx_byte;
  assign out_o.mem_address = cur.mem_address;
  assign out_o.write_data  = cur.write_data;
  assign out_o.last_in_run = last;

  assign pop_o = xfer & last;

  always_comb begin
    sel_d = sel_q;
    if (xfer) begin
      sel_d = ~last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

// File: hdl/serial_load_dump_command_engine.sv
// Top level of the serial load/dump command engine: parser, result queue and result sequencer.
//
// The engine parses a byte-serial command stream (Load, Dump, Go, Ping) and
// turns it into memory writes, memory read requests, jump requests and bytes
// to transmit. Each input transfer is either a byte received from the link or
// a data byte returned for an outstanding dump read. The parser accepts one
// input transfer per clock cycle as long as the result queue has a free
// entry, and all results of an item are placed into the queue as one entry in
// the cycle the item is accepted, so the first result is registered in the
// queue before it is offered on the output. Results leave at one transfer per
// cycle while the output is ready; the read return of a dump causes two results
// (the data byte, then the next read request) unless it ends the dump. The
// queue depth (QueueDepth entries) sets how far the input may run ahead of a
// stalled output. Unknown command bytes, link bytes while a dump read is
// pending and read data without a pending read produce no result.
module serial_load_dump_command_engine import sld_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sld_in_if.sink    in_i,
  sld_out_if.source out_o
);

  push_t  front_push;
  entry_t fifo_head;
  logic   fifo_full;
  logic   fifo_empty;
  logic   back_pop;

  // Front end: accepts and decodes items whenever the queue has room.
  sld_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .space_i(~fifo_full),
    .push_o (front_push)
  );

  // Queue decoupling the parser from a stalling result consumer.
  sld_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .pop_i  (back_pop),
    .full_o (fifo_full),
    .empty_o(fifo_empty),
    .head_o (fifo_head)
  );

  // Back end: emits the results of each entry in order, marking the last one.
  sld_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (fifo_head),
    .empty_i(fifo_empty),
    .pop_o  (back_pop),
    .out_o  (out_o)
  );

  // The parser never pushes into a full queue.
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(front_push.push && fifo_full))
    else $error("result entry pushed into a full queue");

  // Only a dump read return yields two results, and the first is the data byte.
  a_first_of_two_is_tx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_in_run) |-> (out_o.result_kind == RK_TX))
    else $error("first of two results is not a transmit byte");

  // After the first of two results is taken, the read request follows at once.
  a_second_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_in_run) |=>
      (out_o.valid && out_o.last_in_run && out_o.result_kind == RK_READ))
    else $error("second result of a dump read return did not follow");

endmodule

// File: test/serial_load_dump_command_engine_test.sv
// Testbench of the serial load/dump command engine: directed and random command streams.
`timescale 1ns / 100ps

// The engine is driven with byte streams of Load, Dump, Go and Ping commands and with the
// memory read returns of a dump. The testbench keeps its own copy of the command parser. It
// updates that copy at every accepted input transfer and queues the results that the parser
// expects. Each result transfer is checked field by field against the oldest queued result.
// Both handshakes idle at random, with occasional stretches where one side never waits.
module serial_load_dump_command_engine_test import sld_pkg::*; ();

  localparam int RandomItems = 550;   // Random items that the engine acts on.
  localparam int MaxWait     = 17;    // Longest idle stretch drawn for one transfer.
  localparam int ReportLimit = 10;    // Mismatches printed in detail.
  localparam int DrainCycles = 40;    // Quiet cycles watched after the last result.

  // One result as the engine should present it on the output channel.
  typedef struct {
    result_kind_e kind;
    logic [7:0]   tx_byte;
    logic [31:0]  mem_address;
    logic [7:0]   write_data;
    logic         last;
  } cmd_result_t;

  logic clk;
  logic rst_n;

  sld_in_if  in_bus ();
  sld_out_if out_bus ();

  serial_load_dump_command_engine dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Parser state as the testbench tracks it. It changes only when an input transfer is
  // accepted, so it always matches what the engine has seen so far.
  phase_e      eng_phase;
  op_e         eng_op;
  logic [1:0]  eng_field_count;
  logic [31:0] eng_base;
  logic [31:0] eng_length;
  logic [31:0] eng_index;
  logic [7:0]  eng_xor;

  cmd_result_t pending_results[$];  // Results still due from the engine, oldest first.
  int          useful_items;        // Accepted items that the engine did not ignore.
  int          mismatch_count;
  bit          in_rush;             // When set, the sender does not idle.
  bit          out_rush;            // When set, the receiver does not stall.

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog. A correct run needs well under a millisecond.
  initial begin
    #(10_000_000);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Command parser prediction.
  // ---------------------------------------------------------------------------------------

  function automatic cmd_result_t make_result(result_kind_e kind, logic [7:0] tx,
                                              logic [31:0] addr, logic [7:0] wd);
    cmd_result_t r;
    r.kind        = kind;
    r.tx_byte     = tx;
    r.mem_address = addr;
    r.write_data  = wd;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic void engine_go_idle();
    eng_phase       = PH_IDLE;
    eng_op          = OP_NONE;
    eng_field_count = 2'd0;
  endfunction

  // Applies one accepted item to the parser copy and queues the results it causes.
  function automatic void predict_engine_item(item_kind_e kind, logic [7:0] rx,
                                              logic [7:0] rd);
    cmd_result_t produced[$];
    bit          ignored;
    ignored = 1'b0;
    if (kind == ITEM_READ) begin
      // A read return is only meaningful while a dump read is outstanding. The byte goes
      // out on the link, and the next read follows while the dump has bytes left.
      if (eng_phase == PH_DUMP) begin
        produced.push_back(make_result(RK_TX, rd, 32'h0, 8'h00));
        eng_index = eng_index + 32'd1;
        if (eng_index < eng_length) begin
          produced.push_back(make_result(RK_READ, 8'h00, eng_base + eng_index, 8'h00));
        end else begin
          engine_go_idle();
        end
      end else begin
        ignored = 1'b1;
      end
    end else begin
      case (eng_phase)
        PH_ADDR: begin
          // Address bytes arrive most significant first.
          eng_base        = {eng_base[23:0], rx};
          eng_field_count = eng_field_count + 2'd1;
          if (eng_field_count == 2'd0) begin
            if (eng_op == OP_GO) begin
              produced.push_back(make_result(RK_JUMP, 8'h00, eng_base, 8'h00));
              engine_go_idle();
            end else begin
              eng_phase = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          eng_length      = {eng_length[23:0], rx};
          eng_field_count = eng_field_count + 2'd1;
          if (eng_field_count == 2'd0) begin
            eng_index = 32'd0;
            eng_xor   = 8'h00;
            if (eng_op == OP_LOAD) begin
              // An empty load skips straight to its checksum byte.
              if (eng_length == 32'd0) begin
                eng_phase = PH_CSUM;
              end else begin
                eng_phase = PH_DATA;
              end
            end else if (eng_length == 32'd0) begin
              // An empty dump finishes without any result.
              engine_go_idle();
            end else begin
              eng_phase = PH_DUMP;
              produced.push_back(make_result(RK_READ, 8'h00, eng_base, 8'h00));
            end
          end
        end
        PH_DATA: begin
          produced.push_back(make_result(RK_WRITE, 8'h00, eng_base + eng_index, rx));
          eng_xor   = eng_xor ^ rx;
          eng_index = eng_index + 32'd1;
          if (eng_index >= eng_length) begin
            eng_phase = PH_CSUM;
          end
        end
        PH_CSUM: begin
          if (eng_xor == rx) begin
            produced.push_back(make_result(RK_TX, CharOk, 32'h0, 8'h00));
          end else begin
            produced.push_back(make_result(RK_TX, CharError, 32'h0, 8'h00));
          end
          engine_go_idle();
        end
        PH_DUMP: begin
          // Link bytes are dropped while a dump read is outstanding.
          ignored = 1'b1;
        end
        default: begin
          engine_go_idle();
          case (rx)
            CharLoad, CharDump, CharGo: begin
              if (rx == CharLoad) begin
                eng_op = OP_LOAD;
              end else if (rx == CharDump) begin
                eng_op = OP_DUMP;
              end else begin
                eng_op = OP_GO;
              end
              eng_phase  = PH_ADDR;
              eng_base   = 32'h0;
              eng_length = 32'h0;
            end
            CharPing: begin
              produced.push_back(make_result(RK_TX, CharPong, 32'h0, 8'h00));
            end
            default: begin
              ignored = 1'b1;
            end
          endcase
        end
      endcase
    end
    if (produced.size() > 0) begin
      produced[produced.size() - 1].last = 1'b1;
    end
    foreach (produced[i]) begin
      pending_results.push_back(produced[i]);
    end
    if (!ignored) begin
      useful_items++;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------

  // Idle cycles before the next transfer. Now and then a side flips into or out of a
  // stretch where it never waits, so back-to-back traffic is covered as well.
  function automatic int draw_wait(inout bit rush);
    if ($urandom_range(0, 31) == 0) begin
      rush = ~rush;
    end
    if (rush) begin
      return 0;
    end
    return $urandom_range(0, MaxWait);
  endfunction

  // Offers one item and returns at the edge where it is accepted. Valid stays high from
  // one item to the next when no idle cycles are drawn.
  task automatic send_item(item_kind_e kind, logic [7:0] rx, logic [7:0] rd);
    int gap;
    gap = draw_wait(in_rush);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.command   <= kind;
    in_bus.rx_byte   <= rx;
    in_bus.read_data <= rd;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predict_engine_item(kind, rx, rd);
  endtask

  // The field that an item does not use carries random junk.
  task automatic send_link(logic [7:0] b);
    send_item(ITEM_LINK, b, 8'($urandom));
  endtask

  task automatic send_read(logic [7:0] b);
    send_item(ITEM_READ, 8'($urandom), b);
  endtask

  task automatic send_word(logic [31:0] w);
    send_link(w[31:24]);
    send_link(w[23:16]);
    send_link(w[15:8]);
    send_link(w[7:0]);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Addresses near the top of the space make the address sum wrap.
  function automatic logic [31:0] pick_address();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Mostly short transfers, with a few longer ones.
  function automatic logic [31:0] pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return $urandom_range(0, 4);
    end else if (roll < 95) begin
      return $urandom_range(5, 16);
    end
    return $urandom_range(17, 64);
  endfunction

  task automatic send_load(logic [31:0] addr, logic [31:0] len, bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    send_link(CharLoad);
    send_word(addr);
    send_word(len);
    repeat (len) begin
      b   = pick_byte();
      sum = sum ^ b;
      send_link(b);
    end
    if (bad_sum) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    send_link(sum);
  endtask

  // Answers every read of the dump. Before a return, a stray link byte may be slipped in
  // with the given chance in percent; the engine must drop it.
  task automatic send_dump(logic [31:0] addr, logic [31:0] len, int intrude_pct);
    send_link(CharDump);
    send_word(addr);
    send_word(len);
    while (eng_phase == PH_DUMP) begin
      if ($urandom_range(0, 99) < intrude_pct) begin
        send_link(8'($urandom));
      end
      send_read(pick_byte());
    end
  endtask

  task automatic send_go(logic [31:0] addr);
    send_link(CharGo);
    send_word(addr);
  endtask

  // Completes whatever command the parser is in the middle of. Fields are filled with
  // zeros so that a cut-off header never turns into a huge length.
  task automatic settle_engine();
    while (eng_phase != PH_IDLE) begin
      case (eng_phase)
        PH_DUMP:         send_read(pick_byte());
        PH_ADDR, PH_LEN: send_link(8'h00);
        default:         send_link(pick_byte());
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  task automatic test_ping();
    send_link(CharPing);
  endtask

  // An unknown command byte and read returns with no dump running give nothing.
  task automatic test_ignored_items();
    send_link(8'hFF);
    send_read(8'h00);
    send_read(8'hFF);
  endtask

  task automatic test_go_extreme();
    send_go(32'hFFFF_FFFF);
  endtask

  // An empty load with a zero checksum is acknowledged.
  task automatic test_load_empty();
    send_load(32'h0, 32'd0, 1'b0);
  endtask

  // A two-byte dump at the top address wraps to zero, with a link byte dropped before
  // each read return.
  task automatic test_dump_wrap();
    send_dump(32'hFFFF_FFFF, 32'd2, 100);
  endtask

  // Mostly complete commands with random contents; the rest is noise and commands cut
  // off inside their address field.
  task automatic test_random_traffic();
    int         start;
    int         pick;
    logic [7:0] cmd_char;
    start = useful_items;
    while (useful_items - start < RandomItems) begin
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        send_load(pick_address(), pick_length(), $urandom_range(0, 3) == 0);
      end else if (pick < 13) begin
        send_dump(pick_address(), pick_length(), 20);
      end else if (pick < 15) begin
        send_go(pick_address());
      end else if (pick == 15) begin
        send_link(CharPing);
      end else if (pick == 16) begin
        // Any byte at all; if it happens to start a command, finish that command.
        send_link(8'($urandom));
        settle_engine();
      end else if (pick == 17) begin
        send_read(pick_byte());
      end else begin
        case ($urandom_range(0, 2))
          0:       cmd_char = CharLoad;
          1:       cmd_char = CharDump;
          default: cmd_char = CharGo;
        endcase
        send_link(cmd_char);
        repeat ($urandom_range(0, 3)) send_link(8'($urandom));
        settle_engine();
      end
    end
    settle_engine();
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------------------

  function automatic void note_mismatch(string text);
    if (mismatch_count < ReportLimit) begin
      $display("%0t: mismatch: %s", $time, text);
    end
    mismatch_count++;
  endfunction

  function automatic void check_result();
    cmd_result_t exp;
    if (pending_results.size() == 0) begin
      note_mismatch($sformatf("unexpected result kind %0d tx %h addr %h wd %h last %b",
                              out_bus.result_kind, out_bus.tx_byte, out_bus.mem_address,
                              out_bus.write_data, out_bus.last_in_run));
      return;
    end
    exp = pending_results.pop_front();
    if (out_bus.result_kind !== exp.kind || out_bus.tx_byte !== exp.tx_byte ||
        out_bus.mem_address !== exp.mem_address || out_bus.write_data !== exp.write_data ||
        out_bus.last_in_run !== exp.last) begin
      note_mismatch($sformatf({"expected kind %0d tx %h addr %h wd %h last %b, ",
                               "got kind %0d tx %h addr %h wd %h last %b"},
                              exp.kind, exp.tx_byte, exp.mem_address, exp.write_data,
                              exp.last, out_bus.result_kind, out_bus.tx_byte,
                              out_bus.mem_address, out_bus.write_data,
                              out_bus.last_in_run));
    end
  endfunction

  // Receiver: stalls a random number of cycles before each result, then holds ready
  // high until a transfer happens and checks it. Ready stays high into the next result
  // when no stall is drawn.
  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_wait(out_rush);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      check_result();
    end
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------------

  initial begin
    eng_phase       = PH_IDLE;
    eng_op          = OP_NONE;
    eng_field_count = 2'd0;
    eng_base        = 32'h0;
    eng_length      = 32'h0;
    eng_index       = 32'h0;
    eng_xor         = 8'h00;
    useful_items    = 0;
    mismatch_count  = 0;
    in_rush         = 1'b0;
    out_rush        = 1'b0;

    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.command   <= ITEM_LINK;
    in_bus.rx_byte   <= 8'h00;
    in_bus.read_data <= 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ping();
    test_ignored_items();
    test_go_extreme();
    test_load_empty();
    test_dump_wrap();
    test_random_traffic();
    in_bus.valid <= 1'b0;

    // Let every queued result come out, then watch a while longer for stray results.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/sld_pkg.sv
hdl/sld_if.sv
hdl/sld_front.sv
hdl/sld_fifo.sv
hdl/sld_back.sv
hdl/serial_load_dump_command_engine.sv
test/serial_load_dump_command_engine_test.sv
